// ----- src/mfs_pkg.sv -----
package mfs_pkg;

  localparam int CountWidthDefault = 16;

  localparam logic [7:0] SyncByte    = 8'hFF;
  localparam logic [7:0] SyncMask    = 8'hE0;
  localparam logic [7:0] VerLayMask  = 8'h1E;
  localparam logic [7:0] VerLayL2    = 8'h1C;
  localparam logic [1:0] SrReserved  = 2'd3;
  localparam logic [1:0] ModeMono    = 2'd3;
  localparam logic [1:0] ChanMono    = 2'd1;
  localparam logic [1:0] ChanStereo  = 2'd2;

  typedef enum logic [0:0] {
    ST_SCAN,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic advance;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
  } status_t;

  function automatic logic [18:0] rate_bps_lut(input logic [3:0] idx);
    logic [18:0] r;
    unique case (idx)
      4'd1:    r = 19'd32000;
      4'd2:    r = 19'd48000;
      4'd3:    r = 19'd56000;
      4'd4:    r = 19'd64000;
      4'd5:    r = 19'd80000;
      4'd6:    r = 19'd96000;
      4'd7:    r = 19'd112000;
      4'd8:    r = 19'd128000;
      4'd9:    r = 19'd160000;
      4'd10:   r = 19'd192000;
      4'd11:   r = 19'd224000;
      4'd12:   r = 19'd256000;
      4'd13:   r = 19'd320000;
      4'd14:   r = 19'd384000;
      default: r = 19'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] rate_hz_lut(input logic [1:0] idx);
    logic [15:0] r;
    unique case (idx)
      2'd0:    r = 16'd44100;
      2'd1:    r = 16'd48000;
      2'd2:    r = 16'd32000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // 144 * bit rate / sampling frequency, truncated, padding not included
  function automatic logic [10:0] len_44k1(input logic [3:0] idx);
    logic [10:0] r;
    unique case (idx)
      4'd1:    r = 11'd104;
      4'd2:    r = 11'd156;
      4'd3:    r = 11'd182;
      4'd4:    r = 11'd208;
      4'd5:    r = 11'd261;
      4'd6:    r = 11'd313;
      4'd7:    r = 11'd365;
      4'd8:    r = 11'd417;
      4'd9:    r = 11'd522;
      4'd10:   r = 11'd626;
      4'd11:   r = 11'd731;
      4'd12:   r = 11'd835;
      4'd13:   r = 11'd1044;
      4'd14:   r = 11'd1253;
      default: r = 11'd0;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] len_48k(input logic [3:0] idx);
    logic [10:0] r;
    unique case (idx)
      4'd1:    r = 11'd96;
      4'd2:    r = 11'd144;
      4'd3:    r = 11'd168;
      4'd4:    r = 11'd192;
      4'd5:    r = 11'd240;
      4'd6:    r = 11'd288;
      4'd7:    r = 11'd336;
      4'd8:    r = 11'd384;
      4'd9:    r = 11'd480;
      4'd10:   r = 11'd576;
      4'd11:   r = 11'd672;
      4'd12:   r = 11'd768;
      4'd13:   r = 11'd960;
      4'd14:   r = 11'd1152;
      default: r = 11'd0;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] len_32k(input logic [3:0] idx);
    logic [10:0] r;
    unique case (idx)
      4'd1:    r = 11'd144;
      4'd2:    r = 11'd216;
      4'd3:    r = 11'd252;
      4'd4:    r = 11'd288;
      4'd5:    r = 11'd360;
      4'd6:    r = 11'd432;
      4'd7:    r = 11'd504;
      4'd8:    r = 11'd576;
      4'd9:    r = 11'd720;
      4'd10:   r = 11'd864;
      4'd11:   r = 11'd1008;
      4'd12:   r = 11'd1152;
      4'd13:   r = 11'd1440;
      4'd14:   r = 11'd1728;
      default: r = 11'd0;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] frame_len_lut(input logic [3:0] br_idx,
                                                input logic [1:0] sr_idx);
    logic [10:0] r;
    unique case (sr_idx)
      2'd0:    r = len_44k1(br_idx);
      2'd1:    r = len_48k(br_idx);
      2'd2:    r = len_32k(br_idx);
      default: r = 11'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/mpeg1_layer2_frame_sync.sv -----
// mpeg1 layer ii frame header search: feed the buffer one byte per item,
// setting first_byte_i on the first byte of a scan and last_byte_i on the
// final one. the block keeps a three-byte window and judges a header when
// its fourth byte arrives; on a hit it returns one result item with the
// header offset, bit rate, sample rate, channel count, frame length and a
// flag saying whether the frame fits in remaining_length_i. if the buffer
// ends with no header, one not-found item gives the bytes consumed with the
// last three kept back. after a result the scan is closed and further bytes
// are swallowed until the next first byte. throughput is one byte per clock:
// the header decode and frame-length table lookup are combinational ahead of
// the result register, and a new byte is taken whenever that register is
// empty or being drained, so the result is registered as its byte is taken.
module mpeg1_layer2_frame_sync #(
  parameter int COUNT_WIDTH = mfs_pkg::CountWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] remaining_length_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic        complete_o,
  output logic [15:0] skipped_bytes_o,
  output logic [18:0] bit_rate_o,
  output logic [15:0] sample_rate_o,
  output logic [1:0]  channels_o,
  output logic [10:0] frame_length_o
);
  import mfs_pkg::*;

  // command and status between controller and datapath
  cmd_t    cmd;
  status_t status;

  // scan state and result register handshake
  mfs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  // byte window, counter, header decode and result payload
  mfs_datapath #(
    .CountWidth (COUNT_WIDTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .data_byte_i        (data_byte_i),
    .remaining_length_i (remaining_length_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .found_o            (found_o),
    .complete_o         (complete_o),
    .skipped_bytes_o    (skipped_bytes_o),
    .bit_rate_o         (bit_rate_o),
    .sample_rate_o      (sample_rate_o),
    .channels_o         (channels_o),
    .frame_length_o     (frame_length_o)
  );

endmodule

// ----- src/mfs_ctrl.sv -----
module mfs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             first_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mfs_pkg::cmd_t    cmd_o,
  input  mfs_pkg::status_t status_i
);
  import mfs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   done_eff;
  logic   emit;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  // a first byte reopens a finished scan
  assign done_eff    = (state_q == ST_DONE) && !first_byte_i;
  assign emit        = accept && !done_eff && (status_i.hit || last_byte_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SCAN: begin
        if (accept && (status_i.hit || last_byte_i)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (accept && first_byte_i) begin
          state_d = (status_i.hit || last_byte_i) ? ST_DONE : ST_SCAN;
        end
      end
      default: state_d = ST_SCAN;
    endcase
  end

  always_comb begin
    cmd_o.clear    = first_byte_i;
    cmd_o.advance  = accept && !done_eff;
    cmd_o.load_out = emit;
    out_valid_d    = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SCAN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a byte taken after the scan finished gives no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && state_q == ST_DONE && !first_byte_i) |=> !out_valid_q)
    else $error("result produced after scan finished");

  // every result closes the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (state_q == ST_DONE))
    else $error("scan not closed after result");

  // the final byte of an open scan always yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !done_eff && last_byte_i) |=> out_valid_q)
    else $error("final byte gave no result");

endmodule

// ----- src/mfs_datapath.sv -----
module mfs_datapath #(
  parameter int CountWidth = mfs_pkg::CountWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        data_byte_i,
  input  logic [15:0]       remaining_length_i,
  input  mfs_pkg::cmd_t     cmd_i,
  output mfs_pkg::status_t  status_o,
  output logic              found_o,
  output logic              complete_o,
  output logic [15:0]       skipped_bytes_o,
  output logic [18:0]       bit_rate_o,
  output logic [15:0]       sample_rate_o,
  output logic [1:0]        channels_o,
  output logic [10:0]       frame_length_o
);
  import mfs_pkg::*;

  localparam int SumW = ((CountWidth > 16) ? CountWidth : 16) + 1;

  logic [23:0]           window_q;
  logic [CountWidth-1:0] count_q;

  logic                  found_q;
  logic                  complete_q;
  logic [15:0]           skipped_q;
  logic [18:0]           bps_q;
  logic [15:0]           hz_q;
  logic [1:0]            channels_q;
  logic [10:0]           frame_len_q;

  logic [23:0]           win_eff;
  logic [CountWidth-1:0] cnt_eff, cnt_inc, pos, nf_skip;
  logic [7:0]            h0, h1, h2;
  logic                  hit;
  logic [10:0]           len;
  logic [SumW-1:0]       end_pos, pos_w, nf_w;
  logic                  fits;

  assign win_eff = cmd_i.clear ? 24'd0 : window_q;
  assign cnt_eff = cmd_i.clear ? '0 : count_q;
  assign h0 = win_eff[23:16];
  assign h1 = win_eff[15:8];
  assign h2 = win_eff[7:0];

  assign hit = (cnt_eff >= CountWidth'(3)) && (h0 == SyncByte) &&
               ((h1 & SyncMask) == SyncMask) &&
               ((h1 & VerLayMask) == VerLayL2) && (h2[3:2] != SrReserved);
  assign status_o.hit = hit;

  assign len     = frame_len_lut(h2[7:4], h2[3:2]) + {10'd0, h2[0]};
  assign pos     = cnt_eff - CountWidth'(3);
  assign pos_w   = SumW'(pos);
  assign end_pos = pos_w + SumW'(len);
  assign fits    = end_pos <= SumW'(remaining_length_i);

  // saturating byte counter
  assign cnt_inc = (cnt_eff == '1) ? cnt_eff : cnt_eff + CountWidth'(1);
  assign nf_skip = (cnt_inc >= CountWidth'(3)) ? cnt_inc - CountWidth'(3) : '0;
  assign nf_w    = SumW'(nf_skip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 24'd0;
      count_q  <= '0;
    end else if (cmd_i.advance) begin
      window_q <= {win_eff[15:0], data_byte_i};
      count_q  <= cnt_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      found_q <= hit;
      if (hit) begin
        complete_q  <= fits;
        skipped_q   <= pos_w[15:0];
        bps_q       <= rate_bps_lut(h2[7:4]);
        hz_q        <= rate_hz_lut(h2[3:2]);
        channels_q  <= (data_byte_i[7:6] == ModeMono) ? ChanMono : ChanStereo;
        frame_len_q <= len;
      end else begin
        complete_q  <= 1'b0;
        skipped_q   <= nf_w[15:0];
        bps_q       <= 19'd0;
        hz_q        <= 16'd0;
        channels_q  <= 2'd0;
        frame_len_q <= 11'd0;
      end
    end
  end

  assign found_o         = found_q;
  assign complete_o      = complete_q;
  assign skipped_bytes_o = skipped_q;
  assign bit_rate_o      = bps_q;
  assign sample_rate_o   = hz_q;
  assign channels_o      = channels_q;
  assign frame_length_o  = frame_len_q;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mfs_pkg::*;

  // kinds of entry in the feed queue: a byte to offer, a pause, or a
  // pause that lasts until every predicted result has come back
  typedef enum logic [1:0] {
    ENT_BYTE,
    ENT_IDLE,
    ENT_DRAIN
  } entry_kind_e;

  typedef struct {
    entry_kind_e kind;
    int unsigned idle;
    logic [7:0]  data;
    logic [15:0] remaining;
    logic        first;
    logic        last;
  } feed_entry_t;

  // one decoded header, or the not-found report at buffer end
  typedef struct {
    logic        found;
    logic        complete;
    logic [15:0] skipped;
    logic [18:0] bps;
    logic [15:0] hz;
    logic [1:0]  channels;
    logic [10:0] frame_length;
  } frame_info_t;

  typedef logic [7:0] byte_q_t[$];

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  // block inputs start at known values
  logic        in_valid_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic [15:0] remaining_length_i = '0;
  logic        first_byte_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        out_ready_i = 1'b0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic        found_o;
  logic        complete_o;
  logic [15:0] skipped_bytes_o;
  logic [18:0] bit_rate_o;
  logic [15:0] sample_rate_o;
  logic [1:0]  channels_o;
  logic [10:0] frame_length_o;

  mpeg1_layer2_frame_sync DUT (.*);

  // feed queue filled up front, frames the block should report
  feed_entry_t pending[$];
  frame_info_t expected_frames[$];
  int          n_expected = 0;
  int          got_cnt = 0;
  int          sent_cnt = 0;
  int          errors = 0;
  int          fed = 0;

  // shadow of the scan state, updated on every accepted byte
  logic [23:0] scan_window = '0;
  logic [15:0] scan_count = '0;
  bit          scan_closed = 1'b0;

  // -------------------------------------------------------------------
  // header field decode, written out from the layer ii tables
  // -------------------------------------------------------------------
  function automatic int unsigned rate_bps(input logic [3:0] idx);
    case (idx)
      4'd1:    return 32000;
      4'd2:    return 48000;
      4'd3:    return 56000;
      4'd4:    return 64000;
      4'd5:    return 80000;
      4'd6:    return 96000;
      4'd7:    return 112000;
      4'd8:    return 128000;
      4'd9:    return 160000;
      4'd10:   return 192000;
      4'd11:   return 224000;
      4'd12:   return 256000;
      4'd13:   return 320000;
      4'd14:   return 384000;
      default: return 0;  // free format and the invalid index
    endcase
  endfunction

  function automatic int unsigned rate_hz(input logic [1:0] idx);
    case (idx)
      2'd0:    return 44100;
      2'd1:    return 48000;
      2'd2:    return 32000;
      default: return 0;
    endcase
  endfunction

  // 144 * bit rate / sampling frequency, truncated, plus the padding bit
  function automatic int unsigned frame_bytes(input logic [7:0] h2);
    int unsigned hz;
    hz = rate_hz(h2[3:2]);
    if (hz == 0) return 0;
    return (144 * rate_bps(h2[7:4])) / hz + h2[0];
  endfunction

  // -------------------------------------------------------------------
  // scan tracker: one accepted byte in, at most one frame report out
  // -------------------------------------------------------------------
  task automatic track_byte(input feed_entry_t e);
    frame_info_t r;
    bit          hit;
    int unsigned pos;
    int unsigned flen;
    logic [7:0]  h0, h1, h2;
    r = '{default: '0};
    hit = 1'b0;
    if (e.first) begin
      scan_window = '0;
      scan_count = '0;
      scan_closed = 1'b0;
    end
    // a closed scan swallows bytes until the next first byte
    if (!scan_closed) begin
      h0 = scan_window[23:16];
      h1 = scan_window[15:8];
      h2 = scan_window[7:0];
      // the header is judged when its fourth byte arrives
      if (scan_count >= 3 && h0 == SyncByte && (h1 & SyncMask) == SyncMask &&
          (h1 & VerLayMask) == VerLayL2 && h2[3:2] != SrReserved) begin
        flen = frame_bytes(h2);
        pos = scan_count;
        pos = pos - 3;
        r.found = 1'b1;
        r.complete = (pos + flen <= e.remaining);
        r.skipped = pos[15:0];
        r.bps = 19'(rate_bps(h2[7:4]));
        r.hz = 16'(rate_hz(h2[3:2]));
        r.channels = (e.data[7:6] == ModeMono) ? ChanMono : ChanStereo;
        r.frame_length = flen[10:0];
        hit = 1'b1;
      end
      scan_window = {scan_window[15:0], e.data};
      // byte counter saturates instead of wrapping
      if (scan_count != 16'hFFFF) scan_count = scan_count + 1;
      // buffer ended without a header: last three bytes are kept back
      if (!hit && e.last) begin
        r = '{default: '0};
        r.skipped = (scan_count >= 3) ? scan_count - 16'd3 : 16'd0;
        hit = 1'b1;
      end
      if (hit) begin
        scan_closed = 1'b1;
        expected_frames.push_back(r);
        n_expected++;
      end
    end
  endtask

  // -------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------
  // idle stretch length: mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // filler biased toward sync-like bytes so near misses show up
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0, 1:    return SyncByte;
      2:       return 8'hFC | 8'($urandom_range(0, 1));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // queue one buffer: first byte marked, last_byte on index last_at
  // (none if negative); bytes past last_at hit a closed scan
  task automatic feed_scan(input byte_q_t bytes_q, input logic [15:0] rem,
                           input int last_at, input bit gaps);
    feed_entry_t e;
    e.kind = ENT_BYTE;
    e.idle = 0;
    e.data = '0;
    e.remaining = rem;
    e.first = 1'b0;
    e.last = 1'b0;
    foreach (bytes_q[i]) begin
      if (gaps && $urandom_range(0, 99) >= 55) begin
        e.kind = ENT_IDLE;
        e.idle = idle_len();
        pending.push_back(e);
      end
      e.kind = ENT_BYTE;
      e.data = bytes_q[i];
      e.first = (i == 0);
      e.last = (i == last_at);
      pending.push_back(e);
      if (last_at < 0 || i <= last_at) fed++;
    end
  endtask

  task automatic add_drain();
    feed_entry_t e;
    e.kind = ENT_DRAIN;
    e.idle = 0;
    e.data = '0;
    e.remaining = '0;
    e.first = 1'b0;
    e.last = 1'b0;
    pending.push_back(e);
  endtask

  // one line per mismatch, capped so a broken block cannot flood the log
  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    if (errors < 100)
      $display("mismatch at result %0d, %s: got %0d, want %0d",
               got_cnt, what, got, want);
    errors++;
  endtask

  task automatic check_frame();
    frame_info_t w;
    if (expected_frames.size() == 0) begin
      report_mismatch("result with nothing pending", found_o, 0);
      return;
    end
    w = expected_frames.pop_front();
    if (found_o !== w.found) report_mismatch("found", found_o, w.found);
    if (complete_o !== w.complete) report_mismatch("complete", complete_o, w.complete);
    if (skipped_bytes_o !== w.skipped)
      report_mismatch("skipped_bytes", skipped_bytes_o, w.skipped);
    if (bit_rate_o !== w.bps) report_mismatch("bits per second", bit_rate_o, w.bps);
    if (sample_rate_o !== w.hz)
      report_mismatch("sampling frequency", sample_rate_o, w.hz);
    if (channels_o !== w.channels) report_mismatch("channels", channels_o, w.channels);
    if (frame_length_o !== w.frame_length)
      report_mismatch("frame_length", frame_length_o, w.frame_length);
  endtask

  // -------------------------------------------------------------------
  // driver: pops the feed queue, holds each item until it is taken
  // -------------------------------------------------------------------
  feed_entry_t cur_item;
  int unsigned idle_left = 0;

  always @(posedge clk_i) begin
    feed_entry_t e;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      idle_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        track_byte(cur_item);
        sent_cnt <= sent_cnt + 1;
      end
      // offer something new only once the current item has gone
      if (!in_valid_i || in_ready_o) begin
        if (idle_left != 0) begin
          idle_left <= idle_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          e = pending[0];
          case (e.kind)
            ENT_IDLE: begin
              void'(pending.pop_front());
              idle_left <= e.idle - 1;
              in_valid_i <= 1'b0;
            end
            ENT_DRAIN: begin
              // sender pause until every predicted frame has come back
              if (got_cnt == n_expected) void'(pending.pop_front());
              in_valid_i <= 1'b0;
            end
            default: begin
              void'(pending.pop_front());
              cur_item = e;
              data_byte_i <= e.data;
              remaining_length_i <= e.remaining;
              first_byte_i <= e.first;
              last_byte_i <= e.last;
              in_valid_i <= 1'b1;
            end
          endcase
        end
      end
    end
  end

  // -------------------------------------------------------------------
  // long receiver hold-off, counted here, so the result register fills
  // and the block stops taking bytes while the driver keeps offering
  // -------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_used = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && sent_cnt >= 500) begin
      hold_used <= 1'b1;
      hold_left <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // -------------------------------------------------------------------
  // monitor: random ready, compares every accepted result item
  // -------------------------------------------------------------------
  int unsigned rdy_hold = 0;

  always @(posedge clk_i) begin
    int unsigned nh;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rdy_hold <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_frame();
        got_cnt <= got_cnt + 1;
      end
      // stalls start rarely, so long ready stretches happen too
      nh = rdy_hold;
      if (nh != 0) nh = nh - 1;
      else if ($urandom_range(0, 9) == 0) nh = idle_len();
      rdy_hold <= nh;
      out_ready_i <= (nh == 0) && (hold_left == 0);
    end
  end

  // -------------------------------------------------------------------
  // stimulus and end of run
  // -------------------------------------------------------------------
  initial begin
    byte_q_t     scan_q;
    int          kind;
    int          npre;
    int          last_at;
    int          next_drain;
    int unsigned flen;
    logic [7:0]  h0, h1, h2, h3;
    logic [15:0] rem;

    // header on the final byte: 160k at 44.1k, mono, frame does not fit;
    // the byte after it meets a closed scan
    scan_q = '{8'hFF, 8'hFC, 8'h90, 8'hC0, 8'h12};
    feed_scan(scan_q, 16'd4, 3, 1'b1);
    // 384k at 48k with padding after one skipped byte, full remaining;
    // bytes after the hit, the marked last one included, are swallowed
    scan_q = '{8'h00, 8'hFF, 8'hFD, 8'hE7, 8'h3F, 8'h55, 8'hAA};
    feed_scan(scan_q, 16'hFFFF, 6, 1'b1);
    // single-byte buffer, nothing to skip
    scan_q = '{8'hFF};
    feed_scan(scan_q, 16'd0, 0, 1'b1);
    // reserved sample rate: no header, one byte skipped
    scan_q = '{8'hFF, 8'hFC, 8'h0C, 8'h00};
    feed_scan(scan_q, 16'd0, 3, 1'b1);
    // free-format bit rate: length is the padding byte alone
    scan_q = '{8'hFF, 8'hFC, 8'h01, 8'hC0};
    feed_scan(scan_q, 16'd0, -1, 1'b1);
    // invalid bit-rate index at 32k, padded, exactly fits
    scan_q = '{8'hFF, 8'hFD, 8'hF9, 8'h00};
    feed_scan(scan_q, 16'd1, 3, 1'b1);
    add_drain();

    // random buffers: mostly real headers behind random filler
    next_drain = fed + 150;
    while (fed < 1000) begin
      scan_q.delete();
      kind = $urandom_range(0, 99);
      npre = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      repeat (npre) scan_q.push_back(noise_byte());
      h0 = SyncByte;
      h1 = 8'hFC | 8'($urandom_range(0, 1));
      h2 = {4'($urandom_range(0, 15)), 2'($urandom_range(0, 2)), 2'($urandom_range(0, 3))};
      h3 = 8'($urandom_range(0, 255));
      // broken header: one byte spoiled
      if (kind >= 60 && kind < 80) begin
        case ($urandom_range(0, 2))
          0:       h0 = 8'($urandom_range(0, 254));
          1:       h1 = h1 ^ (8'd1 << $urandom_range(1, 7));
          default: h2[3:2] = SrReserved;
        endcase
      end
      if (kind < 80) begin
        scan_q.push_back(h0);
        scan_q.push_back(h1);
        scan_q.push_back(h2);
        scan_q.push_back(h3);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 8)) scan_q.push_back(8'($urandom_range(0, 255)));
      end
      if (scan_q.size() == 0) scan_q.push_back(noise_byte());
      // trailing bytes inside the buffer, else header on the final byte
      if (kind < 80 && $urandom_range(0, 3) != 0)
        repeat ($urandom_range(0, 4)) scan_q.push_back(noise_byte());
      last_at = scan_q.size() - 1;
      // abandoned scan: no last byte, the next first byte restarts
      if (kind >= 90) last_at = -1;
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 2)) scan_q.push_back(noise_byte());
      // remaining length: random, buffer size, at the frame end or one byte short
      flen = frame_bytes(h2);
      case ($urandom_range(0, 3))
        0:       rem = 16'($urandom_range(0, 65535));
        1:       rem = 16'(scan_q.size());
        2:       rem = 16'(npre + flen);
        default: rem = 16'(npre + flen - 1);
      endcase
      feed_scan(scan_q, rem, last_at, 1'b1);
      if (fed >= next_drain) begin
        add_drain();
        next_drain = fed + 150 + $urandom_range(0, 100);
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all bytes taken, then all results back, then a short tail
    while (pending.size() != 0 || in_valid_i) @(negedge clk_i);
    while (got_cnt != n_expected) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (expected_frames.size() != 0)
      report_mismatch("results never seen", expected_frames.size(), 0);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
